// ----- rtl/arfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the animation RLE frame decoder.
// No dependencies; every other file imports this package.
package arfd_pkg;

   localparam int ADDR_BITS_DEFAULT = 24;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_BPP      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic [1:0] MODE_8BIT  = 2'd0;
   localparam logic [1:0] MODE_16BIT = 2'd1;
   localparam logic [1:0] MODE_24BIT = 2'd2;
   localparam logic [1:0] MODE_OFF   = 2'd3;

   localparam logic [7:0] CODE_EXTRA = 8'h00;
   localparam logic [7:0] CODE_END   = 8'hFF;

   typedef struct packed {
      logic [1:0]  pixel_mode;
      logic [2:0]  out_bytes_per_pixel;
      logic [12:0] frame_height;
      logic [15:0] row_pitch;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [23:0] chunk_size;
   } req_type;

   typedef struct packed {
      logic [23:0] write_address;
      logic [7:0]  pixel_count;
      logic [7:0]  byte_first;
      logic [7:0]  byte_second;
      logic [7:0]  byte_third;
      logic [1:0]  bytes_written;
      logic [2:0]  pixel_stride;
   } rsp_type;

endpackage

// ----- rtl/arfd_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration registers and the registered row pitch product.
// Depends on arfd_pkg.
module arfd_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [arfd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [arfd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output arfd_pkg::cfg_type                    cfg
);
   import arfd_pkg::*;

   logic [1:0]  pixel_mode_ff;
   logic [2:0]  out_bpp_ff;
   logic [12:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [15:0] row_pitch_ff;
   logic [15:0] row_pitch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff   <= 2'd0;
         out_bpp_ff      <= 3'd1;
         frame_width_ff  <= 13'd1;
         frame_height_ff <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PIXEL_MODE:   pixel_mode_ff   <= csr_wdata[1:0];
            CSR_OUT_BPP:      out_bpp_ff      <= csr_wdata[2:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[12:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign row_pitch_in = 16'(out_bpp_ff) * 16'(frame_width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff <= 16'd1;
      end else begin
         row_pitch_ff <= row_pitch_in;
      end
   end

   assign cfg.pixel_mode          = pixel_mode_ff;
   assign cfg.out_bytes_per_pixel = out_bpp_ff;
   assign cfg.frame_height        = frame_height_ff;
   assign cfg.row_pitch           = row_pitch_ff;

endmodule

// ----- rtl/arfd_parser.sv -----
`timescale 1ns / 1ps
// Chunk parser: header, line, code and pixel state plus the per-byte step logic.
// Depends on arfd_pkg.
module arfd_parser #(
   parameter int ADDR_BITS = arfd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  arfd_pkg::req_type req,
   input  arfd_pkg::cfg_type cfg,
   output logic              out_valid,
   output arfd_pkg::rsp_type out_data
);
   import arfd_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_SKIP   = 3'd2;
   localparam logic [2:0] PH_CODE   = 3'd3;
   localparam logic [2:0] PH_EXTRA  = 3'd4;
   localparam logic [2:0] PH_RUN    = 3'd5;
   localparam logic [2:0] PH_LIT    = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   localparam logic [8:0]  RUN_BASE     = 9'd256;
   localparam logic [2:0]  BPP_WORD     = 3'd4;
   localparam logic [23:0] MIN_CHUNK    = 24'd8;
   localparam logic [23:0] POS_MAX      = 24'hFFFFFF;
   localparam logic [23:0] POS_FLAGS_LO = 24'd5;
   localparam logic [23:0] POS_START_HI = 24'd6;
   localparam logic [23:0] POS_START_LO = 24'd7;
   localparam logic [23:0] POS_LINES_HI = 24'd10;
   localparam logic [23:0] POS_LINES_LO = 24'd11;
   localparam logic [23:0] POS_BEGIN    = 24'd13;
   localparam int          FLAG_LINES   = 3;

   logic [23:0]          byte_position_ff, byte_position_in;
   logic [2:0]           phase_ff, phase_in;
   logic [15:0]          start_line_ff, start_line_in;
   logic [15:0]          lines_left_ff, lines_left_in;
   logic [ADDR_BITS-1:0] row_base_ff, row_base_in;
   logic [ADDR_BITS-1:0] pixel_address_ff, pixel_address_in;
   logic [7:0]           code_count_ff, code_count_in;
   logic [15:0]          pixel_bytes_ff, pixel_bytes_in;
   logic [1:0]           byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0]          size_limit_ff, size_limit_in;

   logic [23:0]          pos;
   logic [2:0]           phase_cur;
   logic [15:0]          start_line_cur;
   logic [15:0]          lines_left_cur;
   logic [ADDR_BITS-1:0] row_base_cur;
   logic [ADDR_BITS-1:0] pixel_address_cur;
   logic [7:0]           code_count_cur;
   logic [15:0]          pixel_bytes_cur;
   logic [1:0]           byte_in_pixel_cur;

   logic [7:0]           b;
   logic [10:0]          skip_prod;
   logic [ADDR_BITS-1:0] skip_offset;
   logic [31:0]          base_prod;
   logic [ADDR_BITS-1:0] pitch_ext;
   logic [1:0]           need;
   logic [7:0]           count;
   logic [2:0]           stride;
   logic [10:0]          step;
   logic [31:0]          address_ext;
   logic [15:0]          lines_dec;
   logic [7:0]           count_dec;

   assign b           = req.data_byte;
   assign skip_prod   = 11'(b) * 11'(cfg.out_bytes_per_pixel);
   assign skip_offset = ADDR_BITS'(skip_prod) - ADDR_BITS'(cfg.out_bytes_per_pixel);
   assign base_prod   = 32'(cfg.row_pitch) * 32'(start_line_cur);
   assign pitch_ext   = ADDR_BITS'(cfg.row_pitch);
   assign need        = cfg.pixel_mode + 2'd1;
   assign count       = (phase_cur == PH_RUN) ? code_count_cur : 8'd1;
   assign stride      = (cfg.pixel_mode == MODE_8BIT)  ? 3'd1 :
                        (cfg.pixel_mode == MODE_16BIT) ? 3'd2 :
                        (cfg.out_bytes_per_pixel == BPP_WORD) ? 3'd4 : 3'd3;
   assign step        = 11'(count) * 11'(stride);
   assign address_ext = 32'(pixel_address_cur);
   assign lines_dec   = lines_left_cur - 16'd1;
   assign count_dec   = code_count_cur - 8'd1;

   always_comb begin
      if (req.first_byte) begin
         pos               = 24'd0;
         phase_cur         = (req.chunk_size < MIN_CHUNK) ? PH_DONE : PH_HEADER;
         start_line_cur    = 16'd0;
         lines_left_cur    = 16'd0;
         row_base_cur      = '0;
         pixel_address_cur = '0;
         code_count_cur    = 8'd0;
         pixel_bytes_cur   = 16'd0;
         byte_in_pixel_cur = 2'd0;
         size_limit_in     = req.chunk_size;
      end else begin
         pos               = byte_position_ff;
         phase_cur         = phase_ff;
         start_line_cur    = start_line_ff;
         lines_left_cur    = lines_left_ff;
         row_base_cur      = row_base_ff;
         pixel_address_cur = pixel_address_ff;
         code_count_cur    = code_count_ff;
         pixel_bytes_cur   = pixel_bytes_ff;
         byte_in_pixel_cur = byte_in_pixel_ff;
         size_limit_in     = size_limit_ff;
      end
   end

   always_comb begin
      byte_position_in = (pos != POS_MAX) ? pos + 24'd1 : pos;
      phase_in         = phase_cur;
      start_line_in    = start_line_cur;
      lines_left_in    = lines_left_cur;
      row_base_in      = row_base_cur;
      pixel_address_in = pixel_address_cur;
      code_count_in    = code_count_cur;
      pixel_bytes_in   = pixel_bytes_cur;
      byte_in_pixel_in = byte_in_pixel_cur;
      out_valid        = 1'b0;

      out_data.write_address = address_ext[23:0];
      out_data.pixel_count   = count;
      out_data.byte_first    = b;
      out_data.byte_second   = (cfg.pixel_mode != MODE_8BIT) ? pixel_bytes_cur[7:0] : 8'd0;
      out_data.byte_third    = (cfg.pixel_mode[1]) ? pixel_bytes_cur[15:8] : 8'd0;
      out_data.bytes_written = need;
      out_data.pixel_stride  = stride;

      if (!(phase_cur == PH_IDLE || phase_cur == PH_DONE || pos >= size_limit_in)) begin
         if (cfg.pixel_mode == MODE_OFF) begin
            phase_in = PH_DONE;
         end else begin
            unique case (phase_cur)
               PH_HEADER: begin
                  case (pos)
                     POS_FLAGS_LO: begin
                        if (!b[FLAG_LINES]) begin
                           start_line_in = 16'd0;
                           lines_left_in = 16'(cfg.frame_height);
                           row_base_in   = '0;
                           phase_in      = (cfg.frame_height != 13'd0) ? PH_SKIP : PH_DONE;
                        end
                     end
                     POS_START_HI: start_line_in = {b, 8'd0};
                     POS_START_LO: start_line_in = start_line_cur | 16'(b);
                     POS_LINES_HI: lines_left_in = {b, 8'd0};
                     POS_LINES_LO: lines_left_in = lines_left_cur | 16'(b);
                     POS_BEGIN: begin
                        row_base_in = base_prod[ADDR_BITS-1:0];
                        phase_in    = (lines_left_cur != 16'd0) ? PH_SKIP : PH_DONE;
                     end
                     default: ;
                  endcase
               end
               PH_SKIP: begin
                  pixel_address_in = row_base_cur + skip_offset;
                  phase_in         = PH_CODE;
               end
               PH_EXTRA: begin
                  pixel_address_in = pixel_address_cur + skip_offset;
                  phase_in         = PH_CODE;
               end
               PH_CODE: begin
                  byte_in_pixel_in = 2'd0;
                  pixel_bytes_in   = 16'd0;
                  if (b == CODE_EXTRA) begin
                     phase_in = PH_EXTRA;
                  end else if (b == CODE_END) begin
                     lines_left_in = lines_dec;
                     row_base_in   = row_base_cur + pitch_ext;
                     phase_in      = (lines_dec != 16'd0) ? PH_SKIP : PH_DONE;
                  end else if (b[7]) begin
                     code_count_in = 8'(RUN_BASE - {1'b0, b});
                     phase_in      = PH_RUN;
                  end else begin
                     code_count_in = b;
                     phase_in      = PH_LIT;
                  end
               end
               PH_RUN, PH_LIT: begin
                  if ({1'b0, byte_in_pixel_cur} + 3'd1 < {1'b0, need}) begin
                     pixel_bytes_in   = {pixel_bytes_cur[7:0], b};
                     byte_in_pixel_in = byte_in_pixel_cur + 2'd1;
                  end else begin
                     out_valid        = 1'b1;
                     pixel_address_in = pixel_address_cur + ADDR_BITS'(step);
                     byte_in_pixel_in = 2'd0;
                     pixel_bytes_in   = 16'd0;
                     if (phase_cur == PH_RUN) begin
                        phase_in = PH_CODE;
                     end else begin
                        code_count_in = count_dec;
                        if (count_dec == 8'd0) begin
                           phase_in = PH_CODE;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 24'd0;
         phase_ff         <= PH_IDLE;
         start_line_ff    <= 16'd0;
         lines_left_ff    <= 16'd0;
         row_base_ff      <= '0;
         pixel_address_ff <= '0;
         code_count_ff    <= 8'd0;
         pixel_bytes_ff   <= 16'd0;
         byte_in_pixel_ff <= 2'd0;
         size_limit_ff    <= 24'd0;
      end else if (fire) begin
         byte_position_ff <= byte_position_in;
         phase_ff         <= phase_in;
         start_line_ff    <= start_line_in;
         lines_left_ff    <= lines_left_in;
         row_base_ff      <= row_base_in;
         pixel_address_ff <= pixel_address_in;
         code_count_ff    <= code_count_in;
         pixel_bytes_ff   <= pixel_bytes_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         size_limit_ff    <= size_limit_in;
      end
   end

endmodule

// ----- rtl/animation_rle_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Animation RLE frame decoder top level: input register, chunk parser, result register.
// Takes one chunk byte per transaction and returns at most one frame-buffer write command
// per byte (a literal pixel, or a whole run as one fill). A byte is held in the input
// register and its command is captured in the result register, so the block sustains one
// byte per clock unless a result is held; that is the only back-pressure, and it stalls
// the input side for as long as rsp_stall stays high. Configuration writes are always
// ready; the row pitch product is registered, so allow one idle cycle after a write before
// sending a chunk. Depends on arfd_pkg, arfd_cfg_regs and arfd_parser.
module animation_rle_frame_decoder_top #(
   parameter int ADDR_BITS = arfd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_first_byte,
   input  logic [23:0]                         req_chunk_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [23:0]                         rsp_write_address,
   output logic [7:0]                          rsp_pixel_count,
   output logic [7:0]                          rsp_byte_first,
   output logic [7:0]                          rsp_byte_second,
   output logic [7:0]                          rsp_byte_third,
   output logic [1:0]                          rsp_bytes_written,
   output logic [2:0]                          rsp_pixel_stride,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [arfd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import arfd_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   logic    fire;
   logic    produce;
   rsp_type produce_data;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_hold;

   assign csr_ready = 1'b1;

   arfd_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign fire      = in_valid_ff && !rsp_hold;
   assign req_stall = in_valid_ff && rsp_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff.data_byte  <= req_data_byte;
         in_data_ff.first_byte <= req_first_byte;
         in_data_ff.chunk_size <= req_chunk_size;
      end
   end

   arfd_parser #(
      .ADDR_BITS (ADDR_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (in_data_ff),
      .cfg       (cfg),
      .out_valid (produce),
      .out_data  (produce_data)
   );

   assign rsp_valid_in = rsp_hold || (fire && produce);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         rsp_data_ff <= produce_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_data_ff.write_address;
   assign rsp_pixel_count   = rsp_data_ff.pixel_count;
   assign rsp_byte_first    = rsp_data_ff.byte_first;
   assign rsp_byte_second   = rsp_data_ff.byte_second;
   assign rsp_byte_third    = rsp_data_ff.byte_third;
   assign rsp_bytes_written = rsp_data_ff.bytes_written;
   assign rsp_pixel_stride  = rsp_data_ff.pixel_stride;

endmodule

// ----- rtl/arfd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the animation RLE frame decoder, bound to the top level.
// Depends on arfd_pkg.
module arfd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [7:0]                          req_data_byte,
   input logic                                req_first_byte,
   input logic [23:0]                         req_chunk_size,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [23:0]                         rsp_write_address,
   input logic [7:0]                          rsp_pixel_count,
   input logic [7:0]                          rsp_byte_first,
   input logic [7:0]                          rsp_byte_second,
   input logic [7:0]                          rsp_byte_third,
   input logic [1:0]                          rsp_bytes_written,
   input logic [2:0]                          rsp_pixel_stride,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [arfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [arfd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import arfd_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_address)
                                 && $stable(rsp_byte_first))
      else $error("stalled transaction changed");

   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_pixel_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_count != 8'd0 && rsp_bytes_written != 2'd0
                    && rsp_pixel_stride >= 3'(rsp_bytes_written)
                    && ((rsp_bytes_written == 2'd1) == (rsp_pixel_stride == 3'd1)))
      else $error("inconsistent pixel format in result");

   a_unused_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes_written == 2'd1 |-> rsp_byte_second == 8'd0
                                                 && rsp_byte_third == 8'd0)
      else $error("unused pixel bytes not zero");

endmodule

bind animation_rle_frame_decoder_top arfd_checker u_arfd_checker (.*);
